FILE: hw/rtl/sfd_pkg.sv
// Shared types and constants for the SLIP frame decoder.
`default_nettype none
package sfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [0:0] REG_FRAME_LIMIT = 1'b0;
    localparam logic [CNT_W-1:0] FRAME_LIMIT_RST = 7'd64;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } t_state;

endpackage
`default_nettype wire

FILE: hw/rtl/sfd_if.sv
// Valid/ready channel interfaces for raw input bytes and decoded frame bytes.
`default_nettype none
interface sfd_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface sfd_out_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] frame_byte;
    logic                       last_of_frame;

    modport source (output valid, output frame_byte, output last_of_frame, input ready);
    modport sink (input valid, input frame_byte, input last_of_frame, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sfd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sfd_cfg.sv
// APB register block holding the frame length limit.
`default_nettype none
module sfd_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sfd_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [sfd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [sfd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready,
    output logic      [sfd_pkg::CNT_W-1:0]           o_frame_limit
);

    logic [sfd_pkg::CNT_W-1:0] r_frame_limit;
    logic                      w_sel_limit;

    assign w_sel_limit   = (paddr[2] == sfd_pkg::REG_FRAME_LIMIT);
    assign pready        = 1'b1;
    assign o_frame_limit = r_frame_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= sfd_pkg::FRAME_LIMIT_RST;
        end else if (psel && penable && pwrite && w_sel_limit) begin
            r_frame_limit <= pwdata[sfd_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_limit) begin
            prdata = {{(sfd_pkg::APB_DATA_W - sfd_pkg::CNT_W){1'b0}}, r_frame_limit};
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/slip_frame_decoder_core.sv
// Top level of the SLIP frame decoder: unstuffing, frame store and frame drain.
`default_nettype none
// Takes one raw byte per cycle while no frame is draining and undoes SLIP byte
// stuffing into a frame store of STORE_DEPTH bytes. While a frame is being
// received every byte is accepted without a stall. On the closing END of a frame
// that is non-empty and within the length limit, the input stalls and the frame
// is read back from the store and sent out one byte per item, with the last byte
// flagged. The drain issues no new store read while one is pending (registered
// read followed by the output register), and it waits while the output side is
// not ready. The input stays held off until the last store read is issued.
// Frames longer than the limit and frames with a bad escape code are dropped.
module slip_frame_decoder_core #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    sfd_in_if.sink                                   i_byte,
    sfd_out_if.source                                o_frame,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sfd_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [sfd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [sfd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [sfd_pkg::CNT_W-1:0] DEPTH_C = sfd_pkg::CNT_W'(STORE_DEPTH);

    sfd_pkg::t_state r_state, n_state;

    logic [sfd_pkg::CNT_W-1:0]  r_byte_count, n_byte_count;
    logic                       r_inside, n_inside;
    logic                       r_esc, n_esc;
    logic                       r_ovf, n_ovf;
    logic [sfd_pkg::CNT_W-1:0]  r_drain_cnt, n_drain_cnt;
    logic [sfd_pkg::CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic                       r_rd_pend;
    logic                       r_rd_last;
    logic                       r_out_valid;
    logic [sfd_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;

    logic [sfd_pkg::CNT_W-1:0]  w_frame_limit;
    logic [sfd_pkg::CNT_W-1:0]  w_lim;
    logic                       w_accept;
    logic                       w_rd_issue;
    logic                       w_rd_is_last;
    logic                       w_push;
    logic [sfd_pkg::BYTE_W-1:0] w_push_val;
    logic                       w_we;
    logic [sfd_pkg::BYTE_W-1:0] w_rdata;
    logic [sfd_pkg::BYTE_W-1:0] w_b;

    sfd_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_frame_limit (w_frame_limit)
    );

    sfd_ram #(
        .WIDTH (sfd_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_byte_count[AW-1:0]),
        .i_wdata (w_push_val),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_lim        = (w_frame_limit > DEPTH_C) ? DEPTH_C : w_frame_limit;
    assign w_b          = i_byte.data_byte;
    assign i_byte.ready = (r_state == sfd_pkg::ST_IDLE);
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_rd_issue   = (r_state == sfd_pkg::ST_DRAIN) && !r_rd_pend
                          && (!r_out_valid || o_frame.ready);
    assign w_rd_is_last = (r_rd_idx == r_drain_cnt - 7'd1);

    assign o_frame.valid         = r_out_valid;
    assign o_frame.frame_byte    = r_out_byte;
    assign o_frame.last_of_frame = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sfd_pkg::ST_IDLE;
            r_byte_count <= '0;
            r_inside     <= 1'b0;
            r_esc        <= 1'b0;
            r_ovf        <= 1'b0;
            r_drain_cnt  <= '0;
            r_rd_idx     <= '0;
            r_rd_pend    <= 1'b0;
            r_rd_last    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_inside     <= n_inside;
            r_esc        <= n_esc;
            r_ovf        <= n_ovf;
            r_drain_cnt  <= n_drain_cnt;
            r_rd_idx     <= n_rd_idx;
            r_rd_pend    <= w_rd_issue;
            r_rd_last    <= w_rd_issue && w_rd_is_last;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_out_byte <= w_rdata;
            r_out_last <= r_rd_last;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_inside     = r_inside;
        n_esc        = r_esc;
        n_ovf        = r_ovf;
        n_drain_cnt  = r_drain_cnt;
        n_rd_idx     = r_rd_idx;
        w_push       = 1'b0;
        w_push_val   = w_b;
        w_we         = 1'b0;

        unique case (r_state)
            sfd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    priority if (w_b == sfd_pkg::SLIP_END) begin
                        if (r_inside) begin
                            if (!r_ovf && (r_byte_count != '0)) begin
                                n_state     = sfd_pkg::ST_DRAIN;
                                n_drain_cnt = r_byte_count;
                                n_rd_idx    = '0;
                            end
                            n_inside = 1'b0;
                        end else begin
                            n_inside = 1'b1;
                        end
                        n_byte_count = '0;
                        n_esc        = 1'b0;
                        n_ovf        = 1'b0;
                    end else if (!r_inside) begin
                        n_inside = 1'b0;
                    end else if (r_esc) begin
                        n_esc = 1'b0;
                        if (w_b == sfd_pkg::SLIP_ESC_END) begin
                            w_push     = 1'b1;
                            w_push_val = sfd_pkg::SLIP_END;
                        end else if (w_b == sfd_pkg::SLIP_ESC_ESC) begin
                            w_push     = 1'b1;
                            w_push_val = sfd_pkg::SLIP_ESC;
                        end else begin
                            n_byte_count = '0;
                            n_ovf        = 1'b0;
                            n_inside     = 1'b0;
                        end
                    end else if (w_b == sfd_pkg::SLIP_ESC) begin
                        n_esc = 1'b1;
                    end else begin
                        w_push = 1'b1;
                    end
                end
            end
            sfd_pkg::ST_DRAIN: begin
                if (w_rd_issue) begin
                    n_rd_idx = r_rd_idx + 7'd1;
                    if (w_rd_is_last) begin
                        n_state = sfd_pkg::ST_IDLE;
                    end
                end
            end
        endcase

        if (w_push && !r_ovf) begin
            if (r_byte_count >= w_lim) begin
                n_ovf        = 1'b1;
                n_byte_count = '0;
            end else begin
                w_we         = 1'b1;
                n_byte_count = r_byte_count + 7'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_rd_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> r_out_valid)
        else $error("Store read data did not reach the output register.");

    a_ovf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_byte_count == '0))
        else $error("Overflowed frame still holds a byte count.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= DEPTH_C)
        else $error("Byte count exceeds the frame store depth.");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd_issue && w_rd_is_last) |=> (r_state == sfd_pkg::ST_IDLE))
        else $error("Drain did not end after its last store read.");

    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfd_pkg::ST_DRAIN) |-> !w_we)
        else $error("Frame store written while a frame is being drained.");
`endif

endmodule
`default_nettype wire
